@@ hdl/pqh_pkg.sv @@
// shared types and constants for the per-position quality histogram unit
// no dependencies; every other file but pqh_ram uses these by scoped name
package pqh_pkg;

  // field widths of the input word
  localparam int POS_W    = 10;
  localparam int SCORE_W  = 8;
  localparam int WEIGHT_W = 16;

  // field widths of the result word
  localparam int TOTAL_W   = 48;
  localparam int OUT_CNT_W = 32;
  localparam int LEN_W     = 11;

  // score times weight
  localparam int PROD_W = SCORE_W + WEIGHT_W;

  // packed bus widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 128;

  // operation codes carried on in_tuser
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_en;
    logic look;
    logic update;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ hdl/pqh_ram.sv @@
// generic single write port memory with a registered read port
// no dependencies
module pqh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/pqh_ctrl.sv @@
// sequencing state machine: clearing pass, accept, memory lookup, update
// depends on pqh_pkg
module pqh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pqh_pkg::ctrl_stat_t stat,
  output pqh_pkg::ctrl_cmd_t  cmd
);

  pqh_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pqh_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pqh_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = pqh_pkg::ST_IDLE;
      end
      pqh_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = pqh_pkg::ST_LOOK;
      end
      pqh_pkg::ST_LOOK: begin
        // wait here until the result register can take a new word
        if (stat.out_free) state_nxt = pqh_pkg::ST_UPDATE;
      end
      pqh_pkg::ST_UPDATE: begin
        state_nxt = pqh_pkg::ST_IDLE;
      end
      default: state_nxt = pqh_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      pqh_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      pqh_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      pqh_pkg::ST_LOOK: begin
        cmd.look = 1'b1;
      end
      pqh_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/pqh_datapath.sv @@
// item registers, three statistics memories, saturating update and result register
// depends on pqh_pkg and pqh_ram
module pqh_datapath #(
  parameter int MAX_POSITIONS = 1024,
  parameter int NUM_BINS      = 41,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pqh_pkg::ctrl_cmd_t              cmd,
  output pqh_pkg::ctrl_stat_t             stat,
  input  logic                            in_operation,
  input  logic [pqh_pkg::POS_W-1:0]       in_read_position,
  input  logic [pqh_pkg::SCORE_W-1:0]     in_quality_score,
  input  logic [pqh_pkg::WEIGHT_W-1:0]    in_weight,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic                            out_score_error,
  output logic [pqh_pkg::OUT_CNT_W-1:0]   out_seqs_at_position,
  output logic [pqh_pkg::TOTAL_W-1:0]     out_quality_total,
  output logic [pqh_pkg::OUT_CNT_W-1:0]   out_bin_count,
  output logic [pqh_pkg::LEN_W-1:0]       out_positions_used
);

  localparam int HIST_DEPTH = MAX_POSITIONS * NUM_BINS;
  localparam int PA_W       = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int PCMP_W     = 17;   // holds the largest position count
  localparam int BCMP_W     = pqh_pkg::SCORE_W + 1;

  // accepted item
  logic                          op_r;
  logic [pqh_pkg::POS_W-1:0]     pos_r;
  logic [pqh_pkg::SCORE_W-1:0]   score_r;
  logic [pqh_pkg::WEIGHT_W-1:0]  weight_r;
  logic [pqh_pkg::PROD_W-1:0]    prod_r;

  // clearing pass
  logic [HA_W-1:0] clr_idx_r;
  logic            clr_low;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic                          err_r;
  logic [pqh_pkg::OUT_CNT_W-1:0] seqs_r;
  logic [pqh_pkg::TOTAL_W-1:0]   total_r;
  logic [pqh_pkg::OUT_CNT_W-1:0] bin_r;
  logic [pqh_pkg::LEN_W-1:0]     len_r, len_nxt;

  // decode of the item
  logic                          pos_ok, bin_ok, accum;
  logic [pqh_pkg::SCORE_W-1:0]   bin_sel;
  logic [PA_W-1:0]               pos_addr;
  logic [HA_W-1:0]               hist_addr;
  logic [pqh_pkg::LEN_W-1:0]     pos_plus;

  // memory ports
  logic                   cnt_we, tot_we, hist_we;
  logic [PA_W-1:0]        cnt_addr;
  logic [HA_W-1:0]        h_addr;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_wr, hist_rd, hist_wr;
  logic [pqh_pkg::TOTAL_W-1:0] tot_rd, tot_wr;

  // saturating sums
  logic [COUNT_WIDTH:0]         cnt_sum, hist_sum;
  logic [pqh_pkg::TOTAL_W:0]    tot_sum;
  logic [COUNT_WIDTH-1:0]       cnt_new, hist_new;
  logic [pqh_pkg::TOTAL_W-1:0]  tot_new;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_operation;
      pos_r    <= in_read_position;
      score_r  <= in_quality_score;
      weight_r <= in_weight;
    end
    if (cmd.look) begin
      prod_r <= score_r * weight_r;
    end
  end

  assign pos_ok   = (PCMP_W'(pos_r) < PCMP_W'(MAX_POSITIONS));
  assign bin_ok   = (BCMP_W'(score_r) < BCMP_W'(NUM_BINS));
  assign accum    = (op_r == pqh_pkg::OP_ACCUM);
  assign bin_sel  = bin_ok ? score_r : '0;
  assign pos_addr = PA_W'(pos_r);
  assign hist_addr = HA_W'(pos_r) * HA_W'(NUM_BINS) + HA_W'(bin_sel);
  assign pos_plus = {1'b0, pos_r} + pqh_pkg::LEN_W'(1);

  // clearing pass over the largest store, the small ones ride along
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_en) begin
      clr_idx_r <= clr_idx_r + HA_W'(1);
    end
  end

  assign clr_low       = (clr_idx_r < HA_W'(MAX_POSITIONS));
  assign stat.clr_last = (clr_idx_r == HA_W'(HIST_DEPTH - 1));

  // saturating adds on the looked-up words
  assign cnt_sum  = {1'b0, cnt_rd} + (COUNT_WIDTH + 1)'(weight_r);
  assign hist_sum = {1'b0, hist_rd} + (COUNT_WIDTH + 1)'(weight_r);
  assign tot_sum  = {1'b0, tot_rd} + (pqh_pkg::TOTAL_W + 1)'(prod_r);

  always_comb begin
    cnt_new  = cnt_rd;
    hist_new = hist_rd;
    tot_new  = tot_rd;
    if (accum) begin
      cnt_new  = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];
      hist_new = hist_sum[COUNT_WIDTH] ? '1 : hist_sum[COUNT_WIDTH-1:0];
      tot_new  = tot_sum[pqh_pkg::TOTAL_W] ? '1 : tot_sum[pqh_pkg::TOTAL_W-1:0];
    end
  end

  // memory port muxing
  always_comb begin
    if (cmd.clr_en) begin
      cnt_addr = PA_W'(clr_idx_r);
      h_addr   = clr_idx_r;
      cnt_we   = clr_low;
      tot_we   = clr_low;
      hist_we  = 1'b1;
      cnt_wr   = '0;
      tot_wr   = '0;
      hist_wr  = '0;
    end else begin
      cnt_addr = pos_addr;
      h_addr   = hist_addr;
      cnt_we   = cmd.update && accum && pos_ok;
      tot_we   = cmd.update && accum && pos_ok;
      hist_we  = cmd.update && accum && pos_ok && bin_ok;
      cnt_wr   = cnt_new;
      tot_wr   = tot_new;
      hist_wr  = hist_new;
    end
  end

  pqh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_POSITIONS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_addr),
    .wdata (cnt_wr),
    .raddr (cnt_addr),
    .rdata (cnt_rd)
  );

  pqh_ram #(
    .WIDTH (pqh_pkg::TOTAL_W),
    .DEPTH (MAX_POSITIONS)
  ) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (cnt_addr),
    .wdata (tot_wr),
    .raddr (cnt_addr),
    .rdata (tot_rd)
  );

  pqh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (h_addr),
    .wdata (hist_wr),
    .raddr (h_addr),
    .rdata (hist_rd)
  );

  // highest position tracking
  always_comb begin
    len_nxt = len_r;
    if (cmd.update && accum && pos_ok && (pos_plus > len_r)) begin
      len_nxt = pos_plus;
    end
  end

  // result register, freed by the downstream handshake
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      len_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      err_r   <= !pos_ok || !bin_ok;
      seqs_r  <= pos_ok ? pqh_pkg::OUT_CNT_W'(cnt_new) : '0;
      total_r <= pos_ok ? tot_new : '0;
      bin_r   <= (pos_ok && bin_ok) ? pqh_pkg::OUT_CNT_W'(hist_new) : '0;
    end
  end

  assign out_tvalid           = out_valid_r;
  assign out_score_error      = err_r;
  assign out_seqs_at_position = seqs_r;
  assign out_quality_total    = total_r;
  assign out_bin_count        = bin_r;
  assign out_positions_used   = len_r;

endmodule

@@ hdl/per_position_quality_histogram_unit.sv @@
// top level of the per-position quality histogram unit
// depends on pqh_pkg, pqh_ctrl, pqh_datapath (and through it pqh_ram)
//
// Gathers weighted quality statistics per read position. An accumulate word
// (in_tuser = 0) adds its weight to the position's count, score times weight
// to the position's quality total, and the weight to the histogram bin of the
// score; a read word (in_tuser = 1) only looks them up. Every input word gives
// exactly one result word carrying the count, total and selected bin after the
// update, plus one more than the highest position accumulated so far; all
// counters saturate. A score or bin above NUM_BINS-1 flags out_tuser, skips the
// histogram and returns a zero bin; a position at or above MAX_POSITIONS flags
// out_tuser, updates nothing and returns zeros. Each word passes through accept,
// memory read (held while the result register is full) and saturating update
// with write-back, steps set by the registered read of the statistics memories;
// the result register lets the next word be accepted while a result is still
// waiting. After reset a clearing pass zeroes the memories, sweeping all
// MAX_POSITIONS*NUM_BINS histogram addresses (41984 at the defaults), during which in_tready stays low.
module per_position_quality_histogram_unit #(
  parameter int MAX_POSITIONS = 1024,
  parameter int NUM_BINS      = 41,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // read_position[9:0], quality_score[17:10], weight[33:18], zero pad
  input  logic [pqh_pkg::IN_TDATA_W-1:0]     in_tdata,
  // operation
  input  logic                               in_tuser,
  // result words
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // seqs_at_position[31:0], quality_total[79:32], bin_count[111:80],
  // positions_used[122:112], zero pad
  output logic [pqh_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // score_error
  output logic                               out_tuser
);

  pqh_pkg::ctrl_cmd_t  cmd;
  pqh_pkg::ctrl_stat_t stat;

  // unpacked result fields
  logic [pqh_pkg::OUT_CNT_W-1:0] seqs;
  logic [pqh_pkg::TOTAL_W-1:0]   total;
  logic [pqh_pkg::OUT_CNT_W-1:0] bin;
  logic [pqh_pkg::LEN_W-1:0]     used;

  // sequencer: clear, idle, look, update
  pqh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memories, saturating math and the result register
  pqh_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .NUM_BINS      (NUM_BINS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_operation         (in_tuser),
    .in_read_position     (in_tdata[9:0]),
    .in_quality_score     (in_tdata[17:10]),
    .in_weight            (in_tdata[33:18]),
    .out_tready           (out_tready),
    .out_tvalid           (out_tvalid),
    .out_score_error      (out_tuser),
    .out_seqs_at_position (seqs),
    .out_quality_total    (total),
    .out_bin_count        (bin),
    .out_positions_used   (used)
  );

  // pack result fields, lowest first, pad to whole bytes
  assign out_tdata = {5'b0, used, bin, total, seqs};

endmodule

@@ hdl/pqh_checker.sv @@
// port-level checks for the per-position quality histogram unit
// depends on pqh_pkg; bound to the top level below
module pqh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tuser,
  input logic [pqh_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pqh_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result keeps its contents
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // the memories are being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during clearing pass");

  // one word at a time: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  // nothing accumulated yet means every count is still zero
  a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[122:112] == 11'd0) |->
      (out_tdata[31:0] == 32'd0) && (out_tdata[111:80] == 32'd0))
    else $error("nonzero count before any accumulate");

endmodule

bind per_position_quality_histogram_unit pqh_checker u_pqh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
